// ===== design/oaht_pkg.sv =====
// Shared types, codes and the control program of the open-addressing hash table.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none

package oaht_pkg;

  localparam int KEY_W      = 31;
  localparam int KEY_PAD_W  = 32;
  localparam int DIGIT_BITS = 8;
  localparam int DIV_STEPS  = KEY_PAD_W / DIGIT_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam logic [1:0] DH_PRIME = 2'd3;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  localparam logic [1:0] SCHEME_LINEAR    = 2'd0;
  localparam logic [1:0] SCHEME_QUADRATIC = 2'd1;
  localparam logic [1:0] SCHEME_DOUBLE    = 2'd2;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef struct packed {
    mark_t            mark;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
  } item_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
  } item_out_t;

  // Datapath operation selected by the current control word.
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_IDLE,
    OP_DIV,
    OP_CHECK,
    OP_PROBE,
    OP_RESULT
  } op_t;

  typedef enum logic [2:0] {
    COND_CLR_DONE,
    COND_IN_XFER,
    COND_DIV_DONE,
    COND_SKIP,
    COND_PROBE_END,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [2:0] {
    STEP_CLEAR,
    STEP_IDLE,
    STEP_DIV,
    STEP_CHECK,
    STEP_PROBE,
    STEP_RESULT
  } step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t t_true;
    step_t t_false;
  } ctrl_t;

  typedef struct packed {
    logic clr_done;
    logic in_xfer;
    logic div_done;
    logic skip;
    logic probe_end;
    logic out_free;
  } flags_t;

  // Control store: one word per step, jumping to t_true when the condition holds.
  function automatic ctrl_t program_word(step_t s);
    ctrl_t w;
    case (s)
      STEP_CLEAR:  w = '{OP_CLEAR,  COND_CLR_DONE,  STEP_IDLE,   STEP_CLEAR};
      STEP_IDLE:   w = '{OP_IDLE,   COND_IN_XFER,   STEP_DIV,    STEP_IDLE};
      STEP_DIV:    w = '{OP_DIV,    COND_DIV_DONE,  STEP_CHECK,  STEP_DIV};
      STEP_CHECK:  w = '{OP_CHECK,  COND_SKIP,      STEP_RESULT, STEP_PROBE};
      STEP_PROBE:  w = '{OP_PROBE,  COND_PROBE_END, STEP_RESULT, STEP_PROBE};
      STEP_RESULT: w = '{OP_RESULT, COND_OUT_FREE,  STEP_IDLE,   STEP_RESULT};
      default:     w = '{OP_IDLE,   COND_IN_XFER,   STEP_DIV,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/oaht_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on oaht_pkg for the control word, flag and step types.
`default_nettype none

module oaht_seq (
  input  wire               clk,
  input  wire               rst,
  input  oaht_pkg::flags_t  flags,
  output oaht_pkg::ctrl_t   ctrl
);

  oaht_pkg::step_t step;
  oaht_pkg::step_t step_next;
  logic            cond_true;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= oaht_pkg::STEP_CLEAR;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl = oaht_pkg::program_word(step);
    case (ctrl.cond)
      oaht_pkg::COND_CLR_DONE:  cond_true = flags.clr_done;
      oaht_pkg::COND_IN_XFER:   cond_true = flags.in_xfer;
      oaht_pkg::COND_DIV_DONE:  cond_true = flags.div_done;
      oaht_pkg::COND_SKIP:      cond_true = flags.skip;
      oaht_pkg::COND_PROBE_END: cond_true = flags.probe_end;
      oaht_pkg::COND_OUT_FREE:  cond_true = flags.out_free;
      default:                  cond_true = 1'b0;
    endcase
    step_next = cond_true ? ctrl.t_true : ctrl.t_false;
  end

endmodule

`default_nettype wire

// ===== design/oaht_dp.sv =====
// Datapath of the hash table: slot memory, home-slot divider, probe arithmetic,
// entry count, configuration register and the output register. Uses oaht_pkg.
`default_nettype none

module oaht_dp #(
  parameter int TABLE_SIZE = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  oaht_pkg::ctrl_t      ctrl,
  output oaht_pkg::flags_t     flags,
  input  wire                  cfg_wen,
  input  wire [1:0]            cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  oaht_pkg::item_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output oaht_pkg::item_out_t  out_data
);

  localparam int IW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int W1  = IW + 1;
  localparam int CW  = $clog2(TABLE_SIZE + 1);
  localparam int PW  = $clog2(TABLE_SIZE + 2);
  localparam int D0  = 3 % TABLE_SIZE;
  localparam logic [W1-1:0] TW        = W1'(TABLE_SIZE);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(TABLE_SIZE);
  localparam logic [PW-1:0] LAST_PROBE = PW'(TABLE_SIZE + 1);

  // Sum of two residues whose total stays below twice the table size.
  function automatic logic [IW-1:0] add_mod(logic [W1-1:0] a, logic [W1-1:0] b);
    logic [W1-1:0] s;
    s = a + b;
    if (s >= TW) s = s - TW;
    return s[IW-1:0];
  endfunction

  oaht_pkg::entry_t mem [TABLE_SIZE];
  oaht_pkg::entry_t rdata;

  logic                            mem_we;
  logic [IW-1:0]                   mem_waddr;
  oaht_pkg::entry_t                mem_wdata;

  logic [1:0]                      probe_scheme;
  logic [1:0]                      mode;
  logic [oaht_pkg::KEY_W-1:0]      key;
  logic [oaht_pkg::KEY_PAD_W-1:0]  kshift;
  logic [oaht_pkg::DIV_CNT_W-1:0]  div_cnt;
  logic [IW-1:0]                   home;
  logic [1:0]                      key_mod3;
  logic [IW-1:0]                   cur;
  logic [IW-1:0]                   cur_next;
  logic [IW-1:0]                   clr_cnt;
  logic [CW-1:0]                   entry_count;
  logic [PW-1:0]                   probe_idx;
  logic [IW-1:0]                   sq;
  logic [IW-1:0]                   dm;
  logic [IW-1:0]                   ms;
  logic [IW-1:0]                   dstep;
  logic [1:0]                      res_status;
  logic [IW-1:0]                   res_slot;

  logic [W1-1:0]                   r_acc;
  logic [2:0]                      m_acc;
  logic [1:0]                      step3;
  logic [W1-1:0]                   step_w;
  logic                            is_ins;
  logic                            is_del;
  logic                            skip_full;
  logic                            skip_empty;
  logic                            hit;
  logic                            stop_empty;
  logic [IW+3:0]                   slot_wide;

  assign is_ins     = (mode == oaht_pkg::MODE_INSERT);
  assign is_del     = (mode == oaht_pkg::MODE_DELETE);
  assign skip_full  = is_ins && (entry_count == FULL_CNT);
  assign skip_empty = !is_ins && (entry_count == '0);

  assign in_stall = rst || (ctrl.op != oaht_pkg::OP_IDLE);

  assign flags.clr_done  = (clr_cnt == LAST_SLOT);
  assign flags.in_xfer   = in_valid && !in_stall;
  assign flags.div_done  = (div_cnt == oaht_pkg::DIV_CNT_W'(oaht_pkg::DIV_STEPS - 1));
  assign flags.skip      = skip_full || skip_empty;
  assign flags.probe_end = hit || stop_empty || (probe_idx == LAST_PROBE);
  assign flags.out_free  = !out_valid || !out_stall;

  // Probe evaluation against the entry at the current slot.
  always_comb begin
    if (is_ins) begin
      hit        = (rdata.mark != oaht_pkg::MARK_USED);
      stop_empty = 1'b0;
    end else begin
      hit        = (rdata.mark == oaht_pkg::MARK_USED) && (rdata.key == key);
      stop_empty = (rdata.mark == oaht_pkg::MARK_EMPTY);
    end
  end

  // Eight bits of the key per cycle into both residues, most significant first.
  always_comb begin
    r_acc = {1'b0, home};
    m_acc = {1'b0, key_mod3};
    for (int j = 0; j < oaht_pkg::DIGIT_BITS; j++) begin
      r_acc = {r_acc[IW-1:0], kshift[oaht_pkg::KEY_PAD_W-1-j]};
      if (r_acc >= TW) r_acc = r_acc - TW;
      m_acc = {m_acc[1:0], kshift[oaht_pkg::KEY_PAD_W-1-j]};
      if (m_acc >= 3'd3) m_acc = m_acc - 3'd3;
    end
  end

  // Double hashing step, reduced once so that it is a residue of the table size.
  always_comb begin
    step3  = oaht_pkg::DH_PRIME - key_mod3;
    step_w = W1'(step3);
    if (step_w >= TW) step_w = step_w - TW;
  end

  always_comb begin
    cur_next = cur;
    case (ctrl.op)
      oaht_pkg::OP_DIV: cur_next = r_acc[IW-1:0];
      oaht_pkg::OP_PROBE: begin
        case (probe_scheme)
          oaht_pkg::SCHEME_QUADRATIC: cur_next = add_mod({1'b0, cur}, {1'b0, sq});
          oaht_pkg::SCHEME_DOUBLE:    cur_next = add_mod({1'b0, home}, {1'b0, ms});
          default:                    cur_next = add_mod({1'b0, cur}, W1'(1));
        endcase
      end
      default: cur_next = cur;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = '{oaht_pkg::MARK_USED, key};
    case (ctrl.op)
      oaht_pkg::OP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '{oaht_pkg::MARK_EMPTY, '0};
      end
      oaht_pkg::OP_PROBE: begin
        if (hit && (is_ins || is_del)) begin
          mem_we = 1'b1;
          if (is_del) mem_wdata = '{oaht_pkg::MARK_TOMB, '0};
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Read data always belongs to the slot that cur holds after the edge.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[cur_next];
  end

  assign slot_wide = {4'b0, res_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_scheme <= oaht_pkg::SCHEME_LINEAR;
      clr_cnt      <= '0;
      entry_count  <= '0;
      out_valid    <= 1'b0;
      cur          <= '0;
    end else begin
      if (cfg_wen) probe_scheme <= cfg_wdata;
      cur <= cur_next;
      if ((ctrl.op == oaht_pkg::OP_RESULT) && flags.out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        oaht_pkg::OP_CLEAR: begin
          clr_cnt <= clr_cnt + IW'(1);
        end
        oaht_pkg::OP_IDLE: begin
          if (flags.in_xfer) begin
            mode     <= in_data.mode;
            key      <= in_data.key;
            kshift   <= {1'b0, in_data.key};
            div_cnt  <= '0;
            home     <= '0;
            key_mod3 <= '0;
          end
        end
        oaht_pkg::OP_DIV: begin
          home     <= r_acc[IW-1:0];
          key_mod3 <= m_acc[1:0];
          kshift   <= kshift << oaht_pkg::DIGIT_BITS;
          div_cnt  <= div_cnt + oaht_pkg::DIV_CNT_W'(1);
        end
        oaht_pkg::OP_CHECK: begin
          probe_idx <= PW'(1);
          sq        <= IW'(1);
          dm        <= IW'(D0);
          ms        <= step_w[IW-1:0];
          dstep     <= step_w[IW-1:0];
          res_slot  <= '0;
          if (skip_full) begin
            res_status <= oaht_pkg::STATUS_FULL;
          end else if (skip_empty) begin
            res_status <= oaht_pkg::STATUS_EMPTY;
          end else if (is_ins) begin
            res_status <= oaht_pkg::STATUS_FULL;
          end else begin
            res_status <= oaht_pkg::STATUS_NOTFOUND;
          end
        end
        oaht_pkg::OP_PROBE: begin
          probe_idx <= probe_idx + PW'(1);
          sq        <= add_mod({1'b0, sq}, {1'b0, dm});
          dm        <= add_mod({1'b0, dm}, W1'(2));
          ms        <= add_mod({1'b0, ms}, {1'b0, dstep});
          if (hit) begin
            res_status <= oaht_pkg::STATUS_OK;
            res_slot   <= cur;
            if (is_ins) begin
              entry_count <= entry_count + CW'(1);
            end else if (is_del) begin
              entry_count <= entry_count - CW'(1);
            end
          end
        end
        oaht_pkg::OP_RESULT: begin
          if (flags.out_free) begin
            out_data.status <= res_status;
            out_data.slot   <= slot_wide[3:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_write_only_when_allowed: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (ctrl.op == oaht_pkg::OP_CLEAR || ctrl.op == oaht_pkg::OP_PROBE))
    else $error("slot memory written outside the clear pass or a probe");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_CNT)
    else $error("entry count exceeds table size");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    cur <= LAST_SLOT)
    else $error("probe slot outside the table");

  a_probe_bounded: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == oaht_pkg::OP_PROBE) |-> (probe_idx <= LAST_PROBE && probe_idx != '0))
    else $error("probe index out of range");

  a_xfer_starts_div: assert property (@(posedge clk) disable iff (rst)
    flags.in_xfer |=> (ctrl.op == oaht_pkg::OP_DIV))
    else $error("accepted item did not start the home slot division");

endmodule

`default_nettype wire

// ===== design/open_addressing_hash_table_top.sv =====
// Top level of the open-addressing hash table: microcode sequencer plus datapath.
// Depends on oaht_pkg, oaht_seq and oaht_dp.
//
//   port group   direction   handshake             payload
//   in           to block    in_valid / in_stall   in_data   (mode, key)
//   out          from block  out_valid / out_stall out_data  (status, slot)
//   cfg          to block    cfg_wen               cfg_wdata (probe_scheme)
//
// An operation passes through an accept step, the reduction of the key, a check
// step, up to TABLE_SIZE+1 probes (one slot memory read each) and a result step.
// An insert into a full table, or any other operation on an empty one, skips the
// probe loop. After reset a clearing pass marks every slot empty; no transfer is
// accepted during it.
// The output register holds a result under stall while the next item is taken in.
`default_nettype none

module open_addressing_hash_table_top #(
  parameter int TABLE_SIZE = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_wen,
  input  wire [1:0]            cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  oaht_pkg::item_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output oaht_pkg::item_out_t  out_data
);

  oaht_pkg::ctrl_t  ctrl;
  oaht_pkg::flags_t flags;

  oaht_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  oaht_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .flags     (flags),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/open_addressing_hash_table_top_tb.sv =====
// Self-checking testbench for open_addressing_hash_table_top: directed and random
// insert/delete/search traffic under every probe scheme, each result checked in order.
// Depends on oaht_pkg and the design files of the block.
`default_nettype none

module open_addressing_hash_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TBL         = 16;
  localparam int          POOL_N      = 24;
  localparam int          PHASE_ITEMS = 88;
  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [1:0]  MODE_SPARE   = 2'd3;
  localparam logic [1:0]  SCHEME_SPARE = 2'd3;
  localparam logic [30:0] KEY_MAX      = 31'h7FFF_FFFF;

  logic                clk;
  logic                rst;
  logic                cfg_wen;
  logic [1:0]          cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  oaht_pkg::item_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  oaht_pkg::item_out_t out_data;

  // Shadow copy of the table, used to work out each expected result.
  logic [30:0]     slot_key [TBL];
  oaht_pkg::mark_t slot_mark [TBL];
  int unsigned     live_count;
  logic [1:0]      probe_scheme_r;

  oaht_pkg::item_out_t pending_results [$];
  logic [30:0]         key_pool [POOL_N];
  int unsigned         mismatch_count;
  int unsigned         cycle_count;
  bit                  idle_on;

  open_addressing_hash_table_top #(
    .TABLE_SIZE(TBL)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned next_probe(int unsigned cur, int unsigned home,
                                             int unsigned i, logic [30:0] key);
    int unsigned step;
    case (probe_scheme_r)
      oaht_pkg::SCHEME_QUADRATIC: return (cur + (i * i) % TBL) % TBL;
      oaht_pkg::SCHEME_DOUBLE: begin
        step = oaht_pkg::DH_PRIME - key % oaht_pkg::DH_PRIME;
        return (home + (i * step) % TBL) % TBL;
      end
      default: return (cur + 1) % TBL;
    endcase
  endfunction

  function automatic oaht_pkg::item_out_t predict_table_op(logic [1:0] op,
                                                           logic [30:0] key);
    oaht_pkg::item_out_t r;
    int unsigned         home;
    int unsigned         cur;
    home     = key % TBL;
    cur      = home;
    r.status = oaht_pkg::STATUS_NOTFOUND;
    r.slot   = '0;
    if (op == oaht_pkg::MODE_INSERT) begin
      r.status = oaht_pkg::STATUS_FULL;
      if (live_count < TBL) begin
        for (int unsigned i = 1; i <= TBL + 1; i++) begin
          if (slot_mark[cur] != oaht_pkg::MARK_USED) begin
            slot_key[cur]  = key;
            slot_mark[cur] = oaht_pkg::MARK_USED;
            live_count++;
            r.status = oaht_pkg::STATUS_OK;
            r.slot   = 4'(cur);
            break;
          end
          cur = next_probe(cur, home, i, key);
        end
      end
    end else if (live_count == 0) begin
      r.status = oaht_pkg::STATUS_EMPTY;
    end else begin
      // Tombstones are probed past; an empty slot or a matching key ends the walk early.
      for (int unsigned i = 1; i <= TBL + 1; i++) begin
        if (slot_mark[cur] == oaht_pkg::MARK_EMPTY) break;
        if (slot_mark[cur] == oaht_pkg::MARK_USED && slot_key[cur] == key) begin
          if (op == oaht_pkg::MODE_DELETE) begin
            slot_key[cur]  = '0;
            slot_mark[cur] = oaht_pkg::MARK_TOMB;
            live_count--;
          end
          r.status = oaht_pkg::STATUS_OK;
          r.slot   = 4'(cur);
          break;
        end
        cur = next_probe(cur, home, i, key);
      end
    end
    return r;
  endfunction

  function automatic logic [30:0] stored_key();
    int unsigned start;
    int unsigned idx;
    start = $urandom_range(0, TBL - 1);
    for (int unsigned t = 0; t < TBL; t++) begin
      idx = (start + t) % TBL;
      if (slot_mark[idx] == oaht_pkg::MARK_USED) return slot_key[idx];
    end
    return key_pool[0];
  endfunction

  // Sends one operation; returns in the time step of its transfer.
  task automatic transfer_op(input logic [1:0] op, input logic [30:0] key);
    oaht_pkg::item_in_t word;
    word.mode = op;
    word.key  = key;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_results.push_back(predict_table_op(op, key));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_scheme(input logic [1:0] scheme);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= scheme;
    @(posedge clk);
    cfg_wen        <= 1'b0;
    probe_scheme_r  = scheme;
  endtask

  // Result side: random stall bursts, and an in-order check of every transfer.
  initial begin
    oaht_pkg::item_out_t want;
    int unsigned         stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                   $time, out_data.status, out_data.slot);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.slot !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d, actual %0d",
                     $time, want.slot, out_data.slot);
            mismatch_count++;
          end
        end
      end
      if (!idle_on) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("open_addressing_hash_table_top regression: fail");
    $finish;
  end

  task automatic test_empty_table();
    transfer_op(oaht_pkg::MODE_SEARCH, '0);
    transfer_op(oaht_pkg::MODE_DELETE, KEY_MAX);
    transfer_op(MODE_SPARE, 31'h2AAA_AAAA);
  endtask

  // Runs under the scheme left by reset, so linear probing is expected.
  task automatic test_linear_collisions();
    transfer_op(oaht_pkg::MODE_INSERT, 31'd0);
    transfer_op(oaht_pkg::MODE_INSERT, 31'd16);
    transfer_op(oaht_pkg::MODE_INSERT, 31'd32);
    transfer_op(oaht_pkg::MODE_SEARCH, 31'd32);
    transfer_op(oaht_pkg::MODE_DELETE, 31'd16);
    transfer_op(oaht_pkg::MODE_SEARCH, 31'd32);
    transfer_op(oaht_pkg::MODE_INSERT, 31'd48);
    transfer_op(oaht_pkg::MODE_INSERT, 31'd0);
    transfer_op(oaht_pkg::MODE_SEARCH, 31'd5);
    transfer_op(MODE_SPARE, 31'd48);
    transfer_op(oaht_pkg::MODE_INSERT, KEY_MAX);
    transfer_op(oaht_pkg::MODE_SEARCH, KEY_MAX);
  endtask

  // Key 4 steps by 2 under double hashing and sees only the even slots, so
  // the last insert runs out of probes while the table still has room.
  task automatic test_probe_exhausted();
    set_scheme(oaht_pkg::SCHEME_DOUBLE);
    repeat (7) transfer_op(oaht_pkg::MODE_INSERT, 31'd4);
  endtask

  task automatic test_full_table();
    repeat (TBL) begin
      if (live_count < TBL) begin
        transfer_op(oaht_pkg::MODE_INSERT, 31'(3 * (100 + live_count)));
      end
    end
    transfer_op(oaht_pkg::MODE_INSERT, 31'd77);
    transfer_op(oaht_pkg::MODE_SEARCH, 31'd7);
    transfer_op(oaht_pkg::MODE_DELETE, 31'd7);
  endtask

  task automatic test_random_traffic();
    logic [1:0]  schemes [6];
    int unsigned roll;
    bit          draining;
    logic [1:0]  op;
    logic [30:0] key;
    schemes = '{oaht_pkg::SCHEME_QUADRATIC, oaht_pkg::SCHEME_LINEAR, SCHEME_SPARE,
                oaht_pkg::SCHEME_DOUBLE, oaht_pkg::SCHEME_QUADRATIC,
                oaht_pkg::SCHEME_LINEAR};
    // Half of the keys share home slots 0 to 3 so that probe chains grow long.
    for (int k = 0; k < POOL_N; k++) begin
      key_pool[k] = {27'($urandom),
                     4'(k < 12 ? $urandom_range(0, 3) : $urandom_range(0, 15))};
    end
    foreach (schemes[p]) begin
      idle_on = (p != 5);
      set_scheme(schemes[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        draining = (n < PHASE_ITEMS / 2);
        roll = $urandom_range(0, 99);
        if (roll < 5) op = MODE_SPARE;
        else if (roll < (draining ? 20 : 60)) op = oaht_pkg::MODE_INSERT;
        else if (roll < (draining ? 70 : 75)) op = oaht_pkg::MODE_DELETE;
        else op = oaht_pkg::MODE_SEARCH;
        roll = $urandom_range(0, 99);
        if (roll < 8) key = 31'($urandom);
        else if (roll < 50 && op != oaht_pkg::MODE_INSERT && live_count != 0) begin
          key = stored_key();
        end else key = key_pool[$urandom_range(0, POOL_N - 1)];
        if ($urandom_range(0, 63) == 0) drain_results();
        transfer_op(op, key);
      end
    end
  endtask

  initial begin
    foreach (slot_mark[j]) begin
      slot_mark[j] = oaht_pkg::MARK_EMPTY;
      slot_key[j]  = '0;
    end
    live_count     = 0;
    probe_scheme_r = oaht_pkg::SCHEME_LINEAR;
    mismatch_count = 0;
    idle_on        = 1'b1;
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_wdata <= oaht_pkg::SCHEME_LINEAR;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_linear_collisions();
    test_probe_exhausted();
    test_full_table();
    test_random_traffic();

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("open_addressing_hash_table_top regression: pass");
    end else begin
      $display("open_addressing_hash_table_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/oaht_pkg.sv
design/oaht_seq.sv
design/oaht_dp.sv
design/open_addressing_hash_table_top.sv
tb/open_addressing_hash_table_top_tb.sv
